[design/srtf_pkg.sv]
// ============================================================================
// srtf_pkg
// Shared types and constants of the shortest-remaining-time-first scheduler.
// ============================================================================
`default_nettype none

package srtf_pkg;

    // Fixed field widths of the item ports
    localparam int ID_W     = 8;
    localparam int OP_W     = 2;
    localparam int IN_T_W   = 16;
    localparam int BURST_W  = 16;

    // Input item operation codes
    typedef enum logic [OP_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_TICK  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic latch;       // capture the accepted item
        logic scan_start;  // restart the table scan
        logic rd_en;       // read the next table entry
        logic commit;      // apply the item and load the result
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic in_tick;     // item on the input port is a tick
        logic count_zero;  // table holds no task
        logic scan_last;   // current scan entry is the last loaded one
        logic out_free;    // result register can take a new item
    } status_t;

endpackage

`default_nettype wire

[design/srtf_tick_scheduler.sv]
// ============================================================================
// srtf_tick_scheduler
// Preemptive shortest-remaining-time-first scheduler with a task table.
// ============================================================================
// Usage:
//   Input channel (in_valid / in_stall) carries one item: op selects clear,
//   load or tick; task_id, arrival_time and burst_len matter for a load.
//   Output channel (out_valid / out_stall) returns exactly one result item
//   for every input item, in order.
//   A clear or load goes from accept straight to its commit step. A tick
//   (straight to commit with an empty table) scans the table through its
//   single read port, one entry per cycle, keeping the running minimum
//   of remaining work, then the chosen entry is written back.
//   One item is in work at a time; in_stall is high from accept until the
//   result is loaded into the output register. A new item is accepted
//   while the previous result still waits to be taken.
//   When the receiver stalls, the result is held unchanged and a finished
//   item waits in its commit step until the output register frees up.
//   Reset empties the table, sets time to zero and drops any pending
//   result. Table contents need no clearing: only loaded slots are read.
// ============================================================================
`default_nettype none

module srtf_tick_scheduler #(
    parameter int MAX_TASKS = 16,
    parameter int TIME_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [srtf_pkg::OP_W-1:0]     op,
    input  wire logic [srtf_pkg::ID_W-1:0]     task_id,
    input  wire logic [srtf_pkg::IN_T_W-1:0]   arrival_time,
    input  wire logic [srtf_pkg::BURST_W-1:0]  burst_len,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               ran,
    output logic [srtf_pkg::ID_W-1:0]          run_id,
    output logic [srtf_pkg::IN_T_W-1:0]        slot_end_time,
    output logic                               finished,
    output logic [srtf_pkg::IN_T_W-1:0]        finish_time,
    output logic [srtf_pkg::IN_T_W-1:0]        turnaround,
    output logic [srtf_pkg::IN_T_W-1:0]        waiting,
    output logic                               all_done,
    output logic                               load_error
);

    srtf_pkg::cmd_t    cmd;
    srtf_pkg::status_t sts;

    // Sequencer
    srtf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Table, search and result datapath
    srtf_dp #(
        .MAX_TASKS (MAX_TASKS),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .op            (op),
        .task_id       (task_id),
        .arrival_time  (arrival_time),
        .burst_len     (burst_len),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .ran           (ran),
        .run_id        (run_id),
        .slot_end_time (slot_end_time),
        .finished      (finished),
        .finish_time   (finish_time),
        .turnaround    (turnaround),
        .waiting       (waiting),
        .all_done      (all_done),
        .load_error    (load_error)
    );

endmodule

`default_nettype wire

[design/srtf_ctrl.sv]
// ============================================================================
// srtf_ctrl
// Controller: sequences accept, table scan, drain and commit of one item.
// ============================================================================
`default_nettype none

module srtf_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire srtf_pkg::status_t sts,
    output srtf_pkg::cmd_t        cmd
);

    srtf_pkg::state_t state_reg;
    srtf_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= srtf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            srtf_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.latch = 1'b1;
                    if (sts.in_tick)
                    begin
                        cmd.scan_start = 1'b1;
                        state_next = sts.count_zero ? srtf_pkg::ST_COMMIT : srtf_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = srtf_pkg::ST_COMMIT;
                    end
                end
            end
            srtf_pkg::ST_SCAN:
            begin
                cmd.rd_en = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = srtf_pkg::ST_DRAIN;
                end
            end
            srtf_pkg::ST_DRAIN:
            begin
                // last entry is compared this cycle
                state_next = srtf_pkg::ST_COMMIT;
            end
            srtf_pkg::ST_COMMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = srtf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = srtf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[design/srtf_dp.sv]
// ============================================================================
// srtf_dp
// Datapath: task table memory, running minimum search, time and counters,
// and the result register.
// ============================================================================
`default_nettype none

module srtf_dp #(
    parameter int MAX_TASKS = 16,
    parameter int TIME_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire srtf_pkg::cmd_t                cmd,
    output srtf_pkg::status_t                  sts,
    input  wire logic [srtf_pkg::OP_W-1:0]     op,
    input  wire logic [srtf_pkg::ID_W-1:0]     task_id,
    input  wire logic [srtf_pkg::IN_T_W-1:0]   arrival_time,
    input  wire logic [srtf_pkg::BURST_W-1:0]  burst_len,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               ran,
    output logic [srtf_pkg::ID_W-1:0]          run_id,
    output logic [srtf_pkg::IN_T_W-1:0]        slot_end_time,
    output logic                               finished,
    output logic [srtf_pkg::IN_T_W-1:0]        finish_time,
    output logic [srtf_pkg::IN_T_W-1:0]        turnaround,
    output logic [srtf_pkg::IN_T_W-1:0]        waiting,
    output logic                               all_done,
    output logic                               load_error
);

    localparam int IDXW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNTW = $clog2(MAX_TASKS + 1);
    localparam int CW   = (TIME_BITS > srtf_pkg::BURST_W) ? TIME_BITS : srtf_pkg::BURST_W;
    localparam logic [CNTW-1:0] FULL_COUNT = CNTW'(MAX_TASKS);

    // Task table
    logic [srtf_pkg::ID_W-1:0]    id_mem    [MAX_TASKS];
    logic [TIME_BITS-1:0]         arr_mem   [MAX_TASKS];
    logic [srtf_pkg::BURST_W-1:0] burst_mem [MAX_TASKS];
    logic [srtf_pkg::BURST_W-1:0] rem_mem   [MAX_TASKS];

    // Latched item
    srtf_pkg::op_t                op_reg;
    logic [srtf_pkg::ID_W-1:0]    id_reg;
    logic [TIME_BITS-1:0]         arr_reg;
    logic [srtf_pkg::BURST_W-1:0] burst_reg;

    // Control state
    logic [CNTW-1:0]      task_count_reg;
    logic [CNTW-1:0]      done_count_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic [IDXW-1:0]      scan_idx_reg;
    logic                 rd_valid_reg;
    logic                 have_reg;
    logic                 out_valid_reg;

    // Read stage
    logic [IDXW-1:0]              rd_idx_reg;
    logic [srtf_pkg::ID_W-1:0]    rd_id_reg;
    logic [TIME_BITS-1:0]         rd_arr_reg;
    logic [srtf_pkg::BURST_W-1:0] rd_burst_reg;
    logic [srtf_pkg::BURST_W-1:0] rd_rem_reg;

    // Best candidate so far
    logic [IDXW-1:0]              best_idx_reg;
    logic [srtf_pkg::ID_W-1:0]    best_id_reg;
    logic [TIME_BITS-1:0]         best_arr_reg;
    logic [srtf_pkg::BURST_W-1:0] best_burst_reg;
    logic [srtf_pkg::BURST_W-1:0] best_rem_reg;

    // Result register
    logic                         ran_reg;
    logic [srtf_pkg::ID_W-1:0]    run_id_reg;
    logic [srtf_pkg::IN_T_W-1:0]  end_out_reg;
    logic                         fin_reg;
    logic [srtf_pkg::IN_T_W-1:0]  fin_time_reg;
    logic [srtf_pkg::IN_T_W-1:0]  tat_reg;
    logic [srtf_pkg::IN_T_W-1:0]  wait_reg;
    logic                         all_done_reg;
    logic                         load_err_reg;

    // Commit logic
    logic                         take_better;
    logic                         out_free;
    logic [TIME_BITS-1:0]         end_time;
    logic [TIME_BITS-1:0]         tat;
    logic [CW-1:0]                tat_wide;
    logic [CW-1:0]                burst_wide;
    logic [srtf_pkg::BURST_W-1:0] rem_dec;
    logic                         is_fin;
    logic                         ld_ok;
    logic                         ld_err;
    logic                         wr_en;
    logic                         wr_full;
    logic [IDXW-1:0]              wr_addr;
    logic [srtf_pkg::BURST_W-1:0] wr_rem;
    logic [CNTW-1:0]              task_next;
    logic [CNTW-1:0]              done_next;
    logic [TIME_BITS-1:0]         now_next;
    logic                         res_ran;
    logic                         res_fin;
    logic                         res_tick;

    // Status back to controller
    assign out_free = !out_valid_reg || !out_stall;
    always_comb
    begin
        sts.in_tick    = (srtf_pkg::op_t'(op) == srtf_pkg::OP_TICK);
        sts.count_zero = (task_count_reg == '0);
        sts.scan_last  = ((CNTW'(scan_idx_reg) + CNTW'(1)) == task_count_reg);
        sts.out_free   = out_free;
    end

    // Compare the entry just read against the best one
    assign take_better = rd_valid_reg
                      && (rd_arr_reg <= now_reg)
                      && (rd_rem_reg != '0)
                      && (!have_reg
                          || (rd_rem_reg < best_rem_reg)
                          || ((rd_rem_reg == best_rem_reg) && (rd_arr_reg < best_arr_reg)));

    // Work out the effect of the latched item
    always_comb
    begin
        end_time   = (&now_reg) ? now_reg : now_reg + TIME_BITS'(1);
        tat        = end_time - best_arr_reg;
        tat_wide   = CW'(tat);
        burst_wide = CW'(best_burst_reg);
        rem_dec    = best_rem_reg - srtf_pkg::BURST_W'(1);
        res_tick   = (op_reg == srtf_pkg::OP_TICK);
        res_ran    = res_tick && have_reg;
        is_fin     = res_ran && (best_rem_reg == srtf_pkg::BURST_W'(1));
        res_fin    = is_fin;
        wr_full    = (task_count_reg >= FULL_COUNT);
        ld_err     = (op_reg == srtf_pkg::OP_LOAD) && (wr_full || (burst_reg == '0));
        ld_ok      = (op_reg == srtf_pkg::OP_LOAD) && !ld_err;

        task_next = task_count_reg;
        done_next = done_count_reg;
        now_next  = now_reg;
        wr_en     = 1'b0;
        wr_addr   = best_idx_reg;
        wr_rem    = rem_dec;
        unique case (op_reg)
            srtf_pkg::OP_CLEAR:
            begin
                task_next = '0;
                done_next = '0;
                now_next  = '0;
            end
            srtf_pkg::OP_LOAD:
            begin
                if (ld_ok)
                begin
                    task_next = task_count_reg + CNTW'(1);
                    wr_en     = 1'b1;
                    wr_addr   = task_count_reg[IDXW-1:0];
                    wr_rem    = burst_reg;
                end
            end
            srtf_pkg::OP_TICK:
            begin
                now_next = end_time;
                wr_en    = res_ran;
                if (is_fin)
                begin
                    done_next = done_count_reg + CNTW'(1);
                end
            end
            srtf_pkg::OP_NONE:
            begin
                task_next = task_count_reg;
            end
            default:
            begin
                task_next = task_count_reg;
            end
        endcase
    end

    // Table write (load fills an entry, tick updates the remaining work)
    always_ff @(posedge clk)
    begin
        if (cmd.commit && wr_en)
        begin
            rem_mem[wr_addr] <= wr_rem;
            if (op_reg == srtf_pkg::OP_LOAD)
            begin
                id_mem[wr_addr]    <= id_reg;
                arr_mem[wr_addr]   <= arr_reg;
                burst_mem[wr_addr] <= burst_reg;
            end
        end
    end

    // Table read, one entry per scan cycle
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_idx_reg   <= scan_idx_reg;
            rd_id_reg    <= id_mem[scan_idx_reg];
            rd_arr_reg   <= arr_mem[scan_idx_reg];
            rd_burst_reg <= burst_mem[scan_idx_reg];
            rd_rem_reg   <= rem_mem[scan_idx_reg];
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            task_count_reg <= '0;
            done_count_reg <= '0;
            now_reg        <= '0;
            scan_idx_reg   <= '0;
            rd_valid_reg   <= 1'b0;
            have_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.rd_en;

            // advance the scan pointer
            if (cmd.scan_start)
            begin
                scan_idx_reg <= '0;
            end
            else if (cmd.rd_en)
            begin
                scan_idx_reg <= scan_idx_reg + IDXW'(1);
            end

            // track whether a candidate was found
            if (cmd.scan_start)
            begin
                have_reg <= 1'b0;
            end
            else if (take_better)
            begin
                have_reg <= 1'b1;
            end

            // apply the item
            if (cmd.commit)
            begin
                task_count_reg <= task_next;
                done_count_reg <= done_next;
                now_reg        <= now_next;
            end

            // hold the result until taken
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg    <= srtf_pkg::op_t'(op);
            id_reg    <= task_id;
            arr_reg   <= TIME_BITS'(arrival_time);
            burst_reg <= burst_len;
        end

        if (take_better)
        begin
            best_idx_reg   <= rd_idx_reg;
            best_id_reg    <= rd_id_reg;
            best_arr_reg   <= rd_arr_reg;
            best_burst_reg <= rd_burst_reg;
            best_rem_reg   <= rd_rem_reg;
        end

        if (cmd.commit)
        begin
            ran_reg      <= res_ran;
            run_id_reg   <= res_ran ? best_id_reg : '0;
            end_out_reg  <= res_tick ? srtf_pkg::IN_T_W'(end_time) : '0;
            fin_reg      <= res_fin;
            fin_time_reg <= res_fin ? srtf_pkg::IN_T_W'(end_time) : '0;
            tat_reg      <= res_fin ? srtf_pkg::IN_T_W'(tat) : '0;
            wait_reg     <= (res_fin && (tat_wide >= burst_wide))
                            ? srtf_pkg::IN_T_W'(tat_wide - burst_wide) : '0;
            all_done_reg <= (done_next == task_next);
            load_err_reg <= ld_err;
        end
    end

    // Drive the result port
    assign out_valid     = out_valid_reg;
    assign ran           = ran_reg;
    assign run_id        = run_id_reg;
    assign slot_end_time = end_out_reg;
    assign finished      = fin_reg;
    assign finish_time   = fin_time_reg;
    assign turnaround    = tat_reg;
    assign waiting       = wait_reg;
    assign all_done      = all_done_reg;
    assign load_error    = load_err_reg;

endmodule

`default_nettype wire

[bench/tb_srtf_tick_scheduler.sv]
// ----------------------------------------------------------------------------
// tb_srtf_tick_scheduler
// Self-checking bench for the shortest-remaining-time-first tick scheduler.
// Items go in through a valid/stall channel. A scheduler model in the bench
// predicts the result of each accepted item, and every result taken from the
// output channel is compared field by field against the oldest prediction.
// Directed tests cover clear, load, tick, unused op, load rejects and tie
// breaks. Random phases then run short task sets with varied sender idling
// and receiver stalls.
// ----------------------------------------------------------------------------
module tb_srtf_tick_scheduler;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          TABLE_DEPTH = 16;
    localparam int          TIME_W      = 16;
    localparam logic [15:0] TIME_LIMIT  = 16'hFFFF;
    localparam longint      WATCHDOG_NS = 64'd20_000_000;

    // One scheduler result, in port order
    typedef struct packed {
        logic                      ran;
        logic [srtf_pkg::ID_W-1:0] run_id;
        logic [15:0]               slot_end_time;
        logic                      finished;
        logic [15:0]               finish_time;
        logic [15:0]               turnaround;
        logic [15:0]               waiting;
        logic                      all_done;
        logic                      load_error;
    } sched_result_t;

    logic                           clk          = 1'b0;
    logic                           rst_n        = 1'b0;
    logic                           in_valid     = 1'b0;
    logic                           in_stall;
    logic [srtf_pkg::OP_W-1:0]      op           = srtf_pkg::OP_CLEAR;
    logic [srtf_pkg::ID_W-1:0]      task_id      = '0;
    logic [srtf_pkg::IN_T_W-1:0]    arrival_time = '0;
    logic [srtf_pkg::BURST_W-1:0]   burst_len    = '0;
    logic                           out_valid;
    logic                           out_stall    = 1'b0;
    logic                           ran;
    logic [srtf_pkg::ID_W-1:0]      run_id;
    logic [srtf_pkg::IN_T_W-1:0]    slot_end_time;
    logic                           finished;
    logic [srtf_pkg::IN_T_W-1:0]    finish_time;
    logic [srtf_pkg::IN_T_W-1:0]    turnaround;
    logic [srtf_pkg::IN_T_W-1:0]    waiting;
    logic                           all_done;
    logic                           load_error;

    // Scheduler model state
    logic [srtf_pkg::ID_W-1:0]      tbl_id      [TABLE_DEPTH];
    logic [15:0]                    tbl_arrival [TABLE_DEPTH];
    logic [15:0]                    tbl_burst   [TABLE_DEPTH];
    logic [15:0]                    tbl_left    [TABLE_DEPTH];
    int unsigned                    n_loaded  = 0;
    int unsigned                    n_done    = 0;
    logic [15:0]                    clock_now = '0;

    sched_result_t        pending_results[$];
    int unsigned          items_sent     = 0;
    int unsigned          mismatch_count = 0;
    int unsigned          send_idle_pct  = 0;
    int unsigned          stall_pct      = 0;

    srtf_tick_scheduler #(
        .MAX_TASKS (TABLE_DEPTH),
        .TIME_BITS (TIME_W)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .task_id       (task_id),
        .arrival_time  (arrival_time),
        .burst_len     (burst_len),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .ran           (ran),
        .run_id        (run_id),
        .slot_end_time (slot_end_time),
        .finished      (finished),
        .finish_time   (finish_time),
        .turnaround    (turnaround),
        .waiting       (waiting),
        .all_done      (all_done),
        .load_error    (load_error)
    );

    always #2 clk = ~clk;

    // Apply one item to the scheduler model and return its result
    function automatic sched_result_t schedule_step(input srtf_pkg::op_t code,
                                                    input logic [srtf_pkg::ID_W-1:0] id,
                                                    input logic [15:0] arr,
                                                    input logic [15:0] burst);
        sched_result_t res;
        logic          found;
        int            best;
        logic [15:0]   end_t;
        logic [15:0]   tat;
        res = '0;
        case (code)
            srtf_pkg::OP_CLEAR:
            begin
                n_loaded  = 0;
                n_done    = 0;
                clock_now = '0;
            end
            srtf_pkg::OP_LOAD:
            begin
                if (n_loaded >= TABLE_DEPTH || burst == 16'd0)
                begin
                    res.load_error = 1'b1;
                end
                else
                begin
                    tbl_id[n_loaded]      = id;
                    tbl_arrival[n_loaded] = arr;
                    tbl_burst[n_loaded]   = burst;
                    tbl_left[n_loaded]    = burst;
                    n_loaded++;
                end
            end
            srtf_pkg::OP_TICK:
            begin
                found = 1'b0;
                best  = 0;
                end_t = (clock_now == TIME_LIMIT) ? TIME_LIMIT : clock_now + 16'd1;
                // pick least remaining work, then earlier arrival, then lower slot
                for (int i = 0; i < n_loaded; i++)
                begin
                    if (tbl_arrival[i] <= clock_now && tbl_left[i] != 16'd0)
                    begin
                        if (!found || tbl_left[i] < tbl_left[best] ||
                            (tbl_left[i] == tbl_left[best] &&
                             tbl_arrival[i] < tbl_arrival[best]))
                        begin
                            best  = i;
                            found = 1'b1;
                        end
                    end
                end
                res.slot_end_time = end_t;
                if (found)
                begin
                    res.ran    = 1'b1;
                    res.run_id = tbl_id[best];
                    tbl_left[best]--;
                    if (tbl_left[best] == 16'd0)
                    begin
                        tat             = end_t - tbl_arrival[best];
                        res.finished    = 1'b1;
                        res.finish_time = end_t;
                        res.turnaround  = tat;
                        res.waiting     = (tat >= tbl_burst[best]) ? tat - tbl_burst[best]
                                                                   : 16'd0;
                        n_done++;
                    end
                end
                clock_now = end_t;
            end
            default: ;
        endcase
        res.all_done = (n_done == n_loaded);
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    // Take results, compare them and drive receiver stalls
    always @(posedge clk)
    begin
        sched_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("result with no item outstanding");
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("ran",           16'(ran),        16'(want.ran));
                check_field("run_id",        16'(run_id),     16'(want.run_id));
                check_field("slot_end_time", slot_end_time,   want.slot_end_time);
                check_field("finished",      16'(finished),   16'(want.finished));
                check_field("finish_time",   finish_time,     want.finish_time);
                check_field("turnaround",    turnaround,      want.turnaround);
                check_field("waiting",       waiting,         want.waiting);
                check_field("all_done",      16'(all_done),   16'(want.all_done));
                check_field("load_error",    16'(load_error), 16'(want.load_error));
            end
        end
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Send one item, holding it until accepted, and record its prediction
    task automatic send_item(input srtf_pkg::op_t code,
                             input logic [srtf_pkg::ID_W-1:0] id,
                             input logic [15:0] arr, input logic [15:0] burst);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        op           <= code;
        task_id      <= id;
        arrival_time <= arr;
        burst_len    <= burst;
        do
            @(posedge clk);
        while (in_stall);
        pending_results.push_back(schedule_step(code, id, arr, burst));
        items_sent++;
    endtask

    // Load a task arriving near the current time with a mostly short burst
    task automatic send_random_load();
        logic [15:0] arr;
        logic [15:0] burst;
        if ($urandom_range(15) == 0)
            arr = 16'($urandom);
        else
            arr = clock_now + 16'($urandom_range(0, 6));
        case ($urandom_range(19))
            0:       burst = 16'd0;
            1:       burst = 16'($urandom);
            default: burst = 16'($urandom_range(1, 6));
        endcase
        send_item(srtf_pkg::OP_LOAD, 8'($urandom), arr, burst);
    endtask

    task automatic test_basic_ops();
        send_item(srtf_pkg::OP_CLEAR, 8'hFF, 16'hFFFF, 16'hFFFF);
        send_item(srtf_pkg::OP_LOAD,  8'hFF, 16'd0, 16'd2);
        send_item(srtf_pkg::OP_LOAD,  8'h00, 16'd1, 16'd1);
        send_item(srtf_pkg::OP_NONE,  8'hA5, 16'h5A5A, 16'hA5A5);
        repeat (4) send_item(srtf_pkg::OP_TICK, 8'h00, 16'd0, 16'd0);
    endtask

    task automatic test_zero_burst();
        send_item(srtf_pkg::OP_CLEAR, 8'h00, 16'd0, 16'd0);
        send_item(srtf_pkg::OP_LOAD,  8'hFF, 16'hFFFF, 16'd0);
        send_item(srtf_pkg::OP_TICK,  8'h00, 16'd0, 16'd0);
    endtask

    task automatic test_full_table();
        send_item(srtf_pkg::OP_CLEAR, 8'h00, 16'd0, 16'd0);
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_item(srtf_pkg::OP_LOAD, 8'(i * 17),
                      (i == TABLE_DEPTH - 1) ? 16'hFFFF : 16'(i),
                      (i == TABLE_DEPTH - 1) ? 16'hFFFF : 16'd1);
        send_item(srtf_pkg::OP_LOAD, 8'h42, 16'd0, 16'd1);
        send_item(srtf_pkg::OP_TICK, 8'h00, 16'd0, 16'd0);
    endtask

    task automatic test_tie_break();
        send_item(srtf_pkg::OP_CLEAR, 8'h00, 16'd0, 16'd0);
        send_item(srtf_pkg::OP_LOAD,  8'd1, 16'd2, 16'd3);
        send_item(srtf_pkg::OP_LOAD,  8'd2, 16'd2, 16'd3);
        send_item(srtf_pkg::OP_LOAD,  8'd3, 16'd1, 16'd3);
        send_item(srtf_pkg::OP_LOAD,  8'd4, 16'd0, 16'd5);
        repeat (8) send_item(srtf_pkg::OP_TICK, 8'h00, 16'd0, 16'd0);
    endtask

    // Mostly whole task sets (clear, loads, ticks) with some noise in between
    task automatic run_random_phase(input int unsigned quota);
        int unsigned stop_at;
        int unsigned n_tasks;
        int unsigned kind;
        stop_at = items_sent + quota;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(99) < 85)
            begin
                if ($urandom_range(9) != 0)
                    send_item(srtf_pkg::OP_CLEAR, 8'($urandom), 16'($urandom),
                              16'($urandom));
                n_tasks = ($urandom_range(9) == 0) ? $urandom_range(15, 19)
                                                   : $urandom_range(1, 8);
                repeat (n_tasks) send_random_load();
                repeat ($urandom_range(n_tasks, n_tasks * 6))
                begin
                    kind = $urandom_range(99);
                    if (kind < 4)
                        send_random_load();
                    else if (kind < 7)
                        send_item(srtf_pkg::OP_NONE, 8'($urandom), 16'($urandom),
                                  16'($urandom));
                    else
                        send_item(srtf_pkg::OP_TICK, 8'($urandom), 16'($urandom),
                                  16'($urandom));
                end
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    send_item(srtf_pkg::op_t'($urandom_range(3)), 8'($urandom),
                              16'($urandom), 16'($urandom));
            end
        end
    endtask

    task automatic test_random();
        send_idle_pct = 0;
        stall_pct     = 0;
        run_random_phase(330);
        send_idle_pct = 80;
        run_random_phase(330);
        send_idle_pct = 0;
        stall_pct     = 80;
        run_random_phase(330);
        send_idle_pct = 33;
        stall_pct     = 33;
        run_random_phase(330);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_ops();
        test_zero_burst();
        test_full_table();
        test_tie_break();
        test_random();
        in_valid <= 1'b0;
        // drain outstanding results, then let the bench idle before the verdict
        stall_pct = 0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #(WATCHDOG_NS);
        $display("FAIL");
        $finish;
    end

endmodule
